// ===== sv/pingpong_record_store_crc16_core_macros.svh =====
// ---------------------------------------------------------------------------
// record store assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef PINGPONG_RECORD_STORE_CRC16_CORE_MACROS_SVH
`define PINGPONG_RECORD_STORE_CRC16_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PRSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record store check failed");
// next-cycle implication
`define PRSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record store check failed");
`else
`define PRSC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PRSC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/prsc_pkg.sv =====
// ---------------------------------------------------------------------------
// record store package
// record layout, operation and status codes, byte-wise crc-16 step
// ---------------------------------------------------------------------------
package prsc_pkg;

   localparam int SET_NUM   = 6;
   localparam int SET_W     = 16;
   localparam int SEQ_W     = 32;
   localparam int MARK_W    = 16;
   localparam int REC_BYTES = 18;
   localparam int REC_W     = REC_BYTES * 8;
   localparam int CNT_W     = $clog2(REC_BYTES);

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] MAGIC_RESET = 16'h5745;

   // operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SAVE   = 2'd1;
   localparam logic [1:0] OP_PRESET = 2'd2;

   // status codes
   localparam logic [2:0] STS_LOADED    = 3'd0;
   localparam logic [2:0] STS_EMPTY     = 3'd1;
   localparam logic [2:0] STS_UNCHANGED = 3'd2;
   localparam logic [2:0] STS_WRITTEN   = 3'd3;
   localparam logic [2:0] STS_PRESET    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_SEAL,
      ST_REPLY
   } state_type;

   typedef logic [SET_NUM-1:0][SET_W-1:0] set_type;

   typedef struct packed {
      logic [MARK_W-1:0] check;
      logic [MARK_W-1:0] mark;
      set_type           set;
      logic [SEQ_W-1:0]  seq;
   } rec_type;

   // record bytes as sent to the crc, first byte in the low bits
   function automatic logic [REC_W-1:0] rec_bits(input rec_type r);
      rec_bits = {r.mark, r.set, r.seq};
   endfunction

   // one byte into crc-16/modbus, eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      crc_byte = v;
   endfunction

endpackage

// ===== sv/pingpong_record_store_crc16_core.sv =====
// ---------------------------------------------------------------------------
// ping-pong record store with crc-16/modbus
// two record slots, newest valid slot on load, alternating slot on save
// ---------------------------------------------------------------------------
// usage
//   req channel: one beat per command; tuser carries op and slot, tdata the
//   raw sequence, six settings, mark and check (preset uses all of them, save
//   uses the settings, load none).
//   rsp channel: one beat per load, save or preset; op 3 gives no beat.
//   csr channel: writes the 16-bit record mark, taken in any cycle; write it
//   only while no command is in flight.
// sequence
//   load: a crc pass over the 18 record bytes of both slots in parallel, one byte
//   per cycle and slot, then a decide step and a reply step that registers the beat.
//   save that writes: another crc pass on the new record before the reply.
//   preset: straight to the reply step. one command at a time, the next taken
//   once the beat is registered; req_tready is high only when idle.
// reset
//   both slots read as erased (all ones), mark returns to 0x5745.
// stall
//   a beat waiting on rsp_tready does not block the next command; a finished
//   command waits in its reply step until the output register is free.
// ---------------------------------------------------------------------------
module pingpong_record_store_crc16_core (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = op[1:0], slot[2]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,
   // request: tdata = seq_value[31:0], zero_offset, meas_window, avg_window,
   //          full_travel, code_closed, code_open, mark_value, check_value
   input  logic [159:0] req_tdata,
   // response: tuser = status[2:0], slot_used[3]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [3:0]   rsp_tuser,
   // response: tdata = seq_out[31:0], out_offset, out_window, out_avg,
   //           out_travel, out_closed, out_open
   output logic [127:0] rsp_tdata,
   // record mark write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   import prsc_pkg::*;

   state_type         state_ff, state_in;
   rec_type           slot_ff [2];
   rec_type           slot_in [2];
   logic [MARK_W-1:0] magic_ff, magic_in;
   logic [1:0]        op_ff, op_in;
   logic [2:0]        sts_ff, sts_in;
   logic              used_ff, used_in;
   logic              empty_ff, empty_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_user_ff, rsp_user_in;
   logic [127:0]      rsp_data_ff, rsp_data_in;
   set_type           set_ff, set_in;
   logic [REC_W-1:0]  shift_a_ff, shift_a_in;
   logic [REC_W-1:0]  shift_b_ff, shift_b_in;
   logic [15:0]       crc_a_ff, crc_a_in;
   logic [15:0]       crc_b_ff, crc_b_in;

   logic              req_fire;
   logic              last_byte;
   logic              valid_a, valid_b, cur_valid, cur;
   logic [SEQ_W-1:0]  next_seq;
   rec_type           new_rec;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign last_byte  = (cnt_ff == CNT_W'(REC_BYTES - 1));

   // slot validity and newest slot choice
   assign valid_a   = (slot_ff[0].mark == magic_ff) && (crc_a_ff == slot_ff[0].check);
   assign valid_b   = (slot_ff[1].mark == magic_ff) && (crc_b_ff == slot_ff[1].check);
   assign cur_valid = valid_a || valid_b;
   assign cur       = (valid_a && valid_b) ? (slot_ff[0].seq < slot_ff[1].seq) : !valid_a;
   assign next_seq  = cur_valid ? (slot_ff[cur].seq + SEQ_W'(1)) : SEQ_W'(1);

   // record written by a save, check filled in after the crc pass
   always_comb begin
      new_rec       = slot_ff[0];
      new_rec.seq   = next_seq;
      new_rec.set   = set_ff;
      new_rec.mark  = magic_ff;
      new_rec.check = slot_ff[cur_valid ? !cur : 1'b0].check;
   end

   // state register and slots
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff[0]   <= '1;
         slot_ff[1]   <= '1;
         magic_ff     <= MAGIC_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff[0]   <= slot_in[0];
         slot_ff[1]   <= slot_in[1];
         magic_ff     <= magic_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sts_ff      <= sts_in;
      used_ff     <= used_in;
      empty_ff    <= empty_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
      set_ff      <= set_in;
      shift_a_ff  <= shift_a_in;
      shift_b_ff  <= shift_b_in;
      crc_a_ff    <= crc_a_in;
      crc_b_ff    <= crc_b_in;
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      slot_in[0]   = slot_ff[0];
      slot_in[1]   = slot_ff[1];
      magic_in     = magic_ff;
      op_in        = op_ff;
      sts_in       = sts_ff;
      used_in      = used_ff;
      empty_in     = empty_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      set_in       = set_ff;
      shift_a_in   = shift_a_ff;
      shift_b_in   = shift_b_ff;
      crc_a_in     = crc_a_ff;
      crc_b_in     = crc_b_ff;

      // mark register write
      if (csr_valid) begin
         magic_in = csr_data;
      end

      // result beat taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_tuser[1:0];
               set_in = req_tdata[127:32];
               priority if (req_tuser[1:0] == OP_PRESET) begin
                  slot_in[req_tuser[2]] = req_tdata;
                  sts_in   = STS_PRESET;
                  used_in  = req_tuser[2];
                  empty_in = 1'b0;
                  state_in = ST_REPLY;
               end else if (req_tuser[1:0] == OP_LOAD || req_tuser[1:0] == OP_SAVE) begin
                  shift_a_in = rec_bits(slot_ff[0]);
                  shift_b_in = rec_bits(slot_ff[1]);
                  crc_a_in   = CRC_INIT;
                  crc_b_in   = CRC_INIT;
                  cnt_in     = '0;
                  state_in   = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         // one byte per slot per cycle through the crc
         ST_CHECK: begin
            crc_a_in   = crc_byte(crc_a_ff, shift_a_ff[7:0]);
            crc_b_in   = crc_byte(crc_b_ff, shift_b_ff[7:0]);
            shift_a_in = shift_a_ff >> 8;
            shift_b_in = shift_b_ff >> 8;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (last_byte) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            empty_in = 1'b0;
            priority if (op_ff == OP_LOAD) begin
               sts_in   = cur_valid ? STS_LOADED : STS_EMPTY;
               empty_in = !cur_valid;
               used_in  = cur_valid && cur;
               state_in = ST_REPLY;
            end else if (cur_valid && (slot_ff[cur].set == set_ff)) begin
               sts_in   = STS_UNCHANGED;
               used_in  = cur;
               state_in = ST_REPLY;
            end else begin
               // write the other slot (slot 0 if none is valid), then seal it with its crc
               used_in                  = cur_valid ? !cur : 1'b0;
               slot_in[used_in]         = new_rec;
               shift_a_in               = rec_bits(new_rec);
               crc_a_in                 = CRC_INIT;
               cnt_in                   = '0;
               sts_in                   = STS_WRITTEN;
               state_in                 = ST_SEAL;
            end
         end
         ST_SEAL: begin
            crc_a_in   = crc_byte(crc_a_ff, shift_a_ff[7:0]);
            shift_a_in = shift_a_ff >> 8;
            cnt_in     = cnt_ff + CNT_W'(1);
            if (last_byte) begin
               slot_in[used_ff].check = crc_a_in;
               state_in               = ST_REPLY;
            end
         end
         // load the output register once it is free
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {used_ff, sts_ff};
               rsp_data_in  = empty_ff ? '0 : {slot_ff[used_ff].set, slot_ff[used_ff].seq};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   `include "pingpong_record_store_crc16_core_macros.svh"

   `PRSC_ASSERT_IMP(a_seal_only_on_save, clock, reset, state_ff == ST_SEAL, op_ff == OP_SAVE)
   `PRSC_ASSERT_NXT(a_check_ends_in_decide, clock, reset,
                    state_ff == ST_CHECK && last_byte, state_ff == ST_DECIDE)
   `PRSC_ASSERT_IMP(a_empty_reply_is_zero, clock, reset,
                    rsp_valid_ff && rsp_user_ff[2:0] == STS_EMPTY,
                    rsp_data_ff == '0 && !rsp_user_ff[3])

endmodule
